/* rtl/core/meh_pkg.sv */
// Shared constants and types for the masked histogram equaliser.
// Used by meh_hist_mem and masked_histogram_equalizer; no dependencies.
package meh_pkg;

   localparam int NUM_BINS           = 256;
   localparam int BIN_AW             = 8;
   localparam int PIX_W              = 8;
   localparam int OUT_W              = 19;
   localparam int MAX_PIXELS_DEFAULT = 1024;

   // Operation codes of the request word; code three is ignored.
   localparam logic [1:0] OP_CLEAR      = 2'd0;
   localparam logic [1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [1:0] OP_MAP        = 2'd2;

   // Control of the histogram memory from the sequencer.
   typedef struct packed {
      logic              clear;
      logic              rd_en;
      logic [BIN_AW-1:0] rd_addr;
      logic              wr_en;
      logic [BIN_AW-1:0] wr_addr;
   } mem_ctl_type;

endpackage

/* rtl/core/meh_hist_mem.sv */
// Histogram bin memory: 256 entries, one write and one registered read per cycle.
// Per-entry valid bits let one clear strobe empty every entry. Depends on meh_pkg.
module meh_hist_mem #(
   parameter int CNT_W = 11
) (
   input  logic                 clock,
   input  logic                 reset,
   input  meh_pkg::mem_ctl_type ctl,
   input  logic [CNT_W-1:0]     wr_data,
   output logic [CNT_W-1:0]     rd_data
);

   logic [CNT_W-1:0]             bins_ff  [meh_pkg::NUM_BINS];
   logic [meh_pkg::NUM_BINS-1:0] valid_ff;
   logic [CNT_W-1:0]             rd_q_ff;
   logic                         rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         bins_ff[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff <= bins_ff[ctl.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[ctl.wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_valid_ff <= valid_ff[ctl.rd_addr];
         end
      end
   end

   // An entry never written since the last clear reads as an empty bin.
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

/* rtl/core/meh_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; used by masked_histogram_equalizer.
module meh_divider #(
   parameter int NUM_W = 19,
   parameter int DEN_W = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic             rem_nonzero
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [CW-1:0]    cnt_ff;
   logic             run_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         rem_ff  <= '0;
         den_ff  <= denominator;
         quo_ff  <= numerator;
         cnt_ff  <= CW'(NUM_W);
      end else if (run_ff) begin
         rem_ff  <= fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_ff  <= {quo_ff[NUM_W-2:0], fits};
         cnt_ff  <= cnt_ff - CW'(1);
         run_ff  <= cnt_ff != CW'(1);
         done_ff <= cnt_ff == CW'(1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign done        = done_ff;
   assign quotient    = quo_ff;
   assign rem_nonzero = |rem_ff;

endmodule

/* rtl/core/masked_histogram_equalizer.sv */
// Top level of the masked histogram equaliser: sequencer, statistics registers
// and result register. Depends on meh_pkg, meh_hist_mem and meh_divider.
//
// Usage. A request word (req_operation, req_pixel, req_masked) is taken at a
// rising edge where start is high and busy is low. Clear empties the histogram.
// Accumulate counts a masked pixel with a read-modify-write of its bin, read on
// acceptance and written in ST_ACC_WR; an accumulate that is not counted leaves
// the sequencer idle. The first map after accumulation sweeps the 256 bins once
// to build the cumulative histogram, reading one bin and writing the previous
// one in each cycle. Every map then reads the pixel's cumulative bin and divides
// (cdf - min) * 255 by (total - min) in a restoring divider that settles one
// quotient bit per cycle; when the histogram is empty or all its pixels fall in
// one bin, the pixel passes through instead. The result word appears on
// rsp_equalized, marked by rsp_valid for exactly one cycle; the receiver cannot
// stall it, and busy is already low in that cycle. Reset is synchronous and
// leaves an empty, non-cumulative histogram.
module masked_histogram_equalizer #(
   parameter int MAX_PIXELS = meh_pkg::MAX_PIXELS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [meh_pkg::PIX_W-1:0]   req_pixel,
   input  logic                        req_masked,
   output logic                        rsp_valid,
   output logic signed [meh_pkg::OUT_W-1:0] rsp_equalized
);

   // Counts run up to MAX_PIXELS; the numerator carries the factor 255.
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int NUM_W = CNT_W + 8;
   localparam int EXT_W = (NUM_W + 1 > meh_pkg::OUT_W) ? NUM_W + 1 : meh_pkg::OUT_W;
   localparam logic [meh_pkg::BIN_AW:0] SWEEP_END = (meh_pkg::BIN_AW + 1)'(meh_pkg::NUM_BINS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC_WR,
      ST_SWEEP,
      ST_MAP_RD,
      ST_MAP_CALC,
      ST_DIV_WAIT
   } state_type;

   state_type                     state_ff, state_in;
   logic                          is_cum_ff, is_cum_in;
   logic [CNT_W-1:0]              min_ff, min_in;
   logic [CNT_W-1:0]              total_ff, total_in;
   logic [CNT_W-1:0]              run_ff, run_in;
   logic [meh_pkg::BIN_AW:0]      sweep_ff, sweep_in;
   logic [meh_pkg::PIX_W-1:0]     pix_ff, pix_in;
   logic                          neg_ff, neg_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [meh_pkg::OUT_W-1:0]     rsp_eq_ff, rsp_eq_in;

   meh_pkg::mem_ctl_type          mem_ctl;
   logic [CNT_W-1:0]              mem_wr_data;
   logic [CNT_W-1:0]              bin_rd;

   logic                          div_start;
   logic [NUM_W-1:0]              div_num;
   logic [CNT_W-1:0]              div_den;
   logic                          div_done;
   logic [NUM_W-1:0]              div_quo;
   logic                          div_rem_nz;

   logic                          accept;
   logic [CNT_W-1:0]              run_sum;
   logic                          cdf_below;
   logic [CNT_W-1:0]              mag;
   logic [EXT_W-1:0]              quo_ext;
   logic [EXT_W-1:0]              res_ext;

   assign accept    = start && (state_ff == ST_IDLE);
   assign run_sum   = run_ff + bin_rd;
   assign cdf_below = bin_rd < min_ff;
   assign mag       = cdf_below ? (min_ff - bin_rd) : (bin_rd - min_ff);
   // (cdf - min) * 255 as a shift and a subtract, kept as a magnitude.
   assign div_num   = (NUM_W'(mag) << 8) - NUM_W'(mag);
   assign div_den   = total_ff - min_ff;
   // Floor of a negative quotient rounds the magnitude up when a remainder is left.
   assign quo_ext   = EXT_W'(div_quo);
   assign res_ext   = neg_ff ? (EXT_W'(0) - quo_ext - EXT_W'(div_rem_nz)) : quo_ext;

   always_comb begin
      state_in     = state_ff;
      is_cum_in    = is_cum_ff;
      min_in       = min_ff;
      total_in     = total_ff;
      run_in       = run_ff;
      sweep_in     = sweep_ff;
      pix_in       = pix_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_eq_in    = rsp_eq_ff;
      div_start    = 1'b0;
      mem_ctl      = '0;
      mem_ctl.rd_addr = req_pixel;
      mem_ctl.wr_addr = pix_ff;
      mem_wr_data  = bin_rd + CNT_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pix_in = req_pixel;
               case (req_operation)
                  meh_pkg::OP_CLEAR: begin
                     mem_ctl.clear = 1'b1;
                     is_cum_in     = 1'b0;
                     min_in        = '0;
                     total_in      = '0;
                  end
                  meh_pkg::OP_ACCUMULATE: begin
                     if (req_masked && !is_cum_ff && (total_ff < CNT_W'(MAX_PIXELS))) begin
                        mem_ctl.rd_en = 1'b1;
                        total_in      = total_ff + CNT_W'(1);
                        state_in      = ST_ACC_WR;
                     end
                  end
                  meh_pkg::OP_MAP: begin
                     if (is_cum_ff) begin
                        mem_ctl.rd_en = 1'b1;
                        state_in      = ST_MAP_CALC;
                     end else begin
                        sweep_in = '0;
                        run_in   = '0;
                        min_in   = '0;
                        state_in = ST_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ACC_WR: begin
            mem_ctl.wr_en = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SWEEP: begin
            // Read bin k while bin k-1, read last cycle, is written back summed.
            mem_ctl.rd_en   = sweep_ff != SWEEP_END;
            mem_ctl.rd_addr = sweep_ff[meh_pkg::BIN_AW-1:0];
            mem_ctl.wr_addr = sweep_ff[meh_pkg::BIN_AW-1:0] - meh_pkg::BIN_AW'(1);
            mem_wr_data     = run_sum;
            sweep_in        = sweep_ff + (meh_pkg::BIN_AW + 1)'(1);
            if (sweep_ff != '0) begin
               mem_ctl.wr_en = 1'b1;
               run_in        = run_sum;
               if ((min_ff == '0) && (run_sum != '0)) begin
                  min_in = run_sum;
               end
            end
            if (sweep_ff == SWEEP_END) begin
               total_in  = run_sum;
               is_cum_in = 1'b1;
               state_in  = ST_MAP_RD;
            end
         end
         ST_MAP_RD: begin
            mem_ctl.rd_en   = 1'b1;
            mem_ctl.rd_addr = pix_ff;
            state_in        = ST_MAP_CALC;
         end
         ST_MAP_CALC: begin
            if (total_ff > min_ff) begin
               div_start = 1'b1;
               neg_in    = cdf_below;
               state_in  = ST_DIV_WAIT;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_eq_in    = meh_pkg::OUT_W'(pix_ff);
               state_in     = ST_IDLE;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_eq_in    = res_ext[meh_pkg::OUT_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         is_cum_ff    <= 1'b0;
         min_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_cum_ff    <= is_cum_in;
         min_ff       <= min_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      run_ff    <= run_in;
      sweep_ff  <= sweep_in;
      pix_ff    <= pix_in;
      neg_ff    <= neg_in;
      rsp_eq_ff <= rsp_eq_in;
   end

   meh_hist_mem #(
      .CNT_W (CNT_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .wr_data (mem_wr_data),
      .rd_data (bin_rd)
   );

   meh_divider #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .done        (div_done),
      .quotient    (div_quo),
      .rem_nonzero (div_rem_nz)
   );

   assign busy          = state_ff != ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_equalized = rsp_eq_ff;

   // A result word only ever follows the final step of a map.
   a_rsp_after_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_MAP_CALC || $past(state_ff) == ST_DIV_WAIT))
      else $error("result word without a map in progress");

   // The sequencer is back to idle whenever it presents a result.
   a_idle_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy)
      else $error("result word while still busy");

   // The pixel count saturates at its limit.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel count beyond its limit");

   // A clear drops the statistics in the following cycle.
   a_clear_stats: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == meh_pkg::OP_CLEAR) |=> (!is_cum_ff && total_ff == '0))
      else $error("clear left statistics behind");

   // The divider is only started from the sequencer step that expects it.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == ST_DIV_WAIT))
      else $error("divider started outside a map");

endmodule
